FILE: hw/rtl/aam_pkg.sv
package aam_pkg;

	// Field widths of the streaming interface.
	localparam int AAM_VALUE_W    = 64;
	localparam int AAM_INDEX_W    = 16;
	localparam int AAM_POS_W      = 10;
	localparam int AAM_CFG_DATA_W = 17;
	localparam int AAM_CFG_IDX_W  = 2;

	// Inner positions addressable through the 10-bit position field.
	localparam int AAM_POS_LIMIT = 1024;

	// Default table depth, and the largest axis length the block accepts.
	localparam int AAM_MAX_INNER = 1024;
	localparam int AAM_MAX_AXIS  = 65536;

	localparam int AAM_AXIS_HI_INT = (AAM_MAX_AXIS < 65536) ? AAM_MAX_AXIS : 65536;
	localparam logic [AAM_CFG_DATA_W-1:0] AAM_AXIS_HI = AAM_CFG_DATA_W'(AAM_AXIS_HI_INT);
	localparam logic [AAM_INDEX_W-1:0] AAM_AXIS_LAST = AAM_INDEX_W'(AAM_AXIS_HI_INT - 1);

	// Configuration register indexes.
	localparam logic [AAM_CFG_IDX_W-1:0] CFG_FIND_MINIMUM = 2'd0;
	localparam logic [AAM_CFG_IDX_W-1:0] CFG_AXIS_LENGTH  = 2'd1;
	localparam logic [AAM_CFG_IDX_W-1:0] CFG_INNER_LENGTH = 2'd2;

	// One accepted element, decoded against the running counters.
	typedef struct packed {
		logic [AAM_VALUE_W-1:0] key;        // sign-flipped value, compares unsigned
		logic [AAM_POS_W-1:0]   pos;
		logic [AAM_INDEX_W-1:0] step;
		logic                   first;      // first element along the axis
		logic                   last_axis;
		logic                   last_inner;
	} aam_item_t;

	// Occupancy of the update stage.
	typedef struct packed {
		logic valid;
		logic last_axis;
	} aam_stage_t;

	// Result leaving the update stage.
	typedef struct packed {
		logic [AAM_INDEX_W-1:0] best_index;
		logic [AAM_POS_W-1:0]   pos;
		logic                   last_inner;
	} aam_result_t;

endpackage

FILE: hw/rtl/aam_sequencer.sv
module aam_sequencer
	import aam_pkg::*;
#(
	parameter int MAX_INNER = AAM_MAX_INNER
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [AAM_CFG_IDX_W-1:0]  cfg_index,
	input  logic [AAM_CFG_DATA_W-1:0] cfg_data,
	input  logic                      accept,
	input  logic [AAM_VALUE_W-1:0]    value,
	output aam_item_t                 item,
	output logic                      find_minimum
);

	localparam int INNER_HI_INT = (MAX_INNER < AAM_POS_LIMIT) ? MAX_INNER : AAM_POS_LIMIT;
	localparam logic [AAM_POS_W:0]   INNER_HI   = (AAM_POS_W + 1)'(INNER_HI_INT);
	localparam logic [AAM_POS_W-1:0] INNER_LAST = AAM_POS_W'(INNER_HI_INT - 1);

	logic                   find_minimum_q;
	logic [AAM_INDEX_W-1:0] axis_last_q;
	logic [AAM_POS_W-1:0]   inner_last_q;
	logic [AAM_INDEX_W-1:0] axis_cnt_q;
	logic [AAM_POS_W-1:0]   inner_cnt_q;

	logic [AAM_POS_W:0]     inner_data;
	logic [AAM_INDEX_W-1:0] axis_last_new;
	logic [AAM_POS_W-1:0]   inner_last_new;
	logic [AAM_POS_W-1:0]   pos;
	logic [AAM_INDEX_W-1:0] step;
	logic                   last_axis;
	logic                   last_inner;

	assign inner_data = cfg_data[AAM_POS_W:0];

	// Lengths are stored as their last index; zero acts as one, large values saturate.
	always_comb begin
		if (cfg_data == '0) begin
			axis_last_new = '0;
		end else if (cfg_data > AAM_AXIS_HI) begin
			axis_last_new = AAM_AXIS_LAST;
		end else begin
			axis_last_new = AAM_INDEX_W'(cfg_data - 1'b1);
		end
		if (inner_data == '0) begin
			inner_last_new = '0;
		end else if (inner_data > INNER_HI) begin
			inner_last_new = INNER_LAST;
		end else begin
			inner_last_new = AAM_POS_W'(inner_data - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_minimum_q <= 1'b0;
			axis_last_q    <= '0;
			inner_last_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIND_MINIMUM: find_minimum_q <= cfg_data[0];
				CFG_AXIS_LENGTH:  axis_last_q    <= axis_last_new;
				CFG_INNER_LENGTH: inner_last_q   <= inner_last_new;
				default: ;
			endcase
		end
	end

	// A counter past a shortened length counts as sitting on the last position.
	assign pos        = (inner_cnt_q > inner_last_q) ? inner_last_q : inner_cnt_q;
	assign step       = (axis_cnt_q > axis_last_q) ? axis_last_q : axis_cnt_q;
	assign last_axis  = (step == axis_last_q);
	assign last_inner = (pos == inner_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_cnt_q  <= '0;
			inner_cnt_q <= '0;
		end else if (accept) begin
			if (last_inner) begin
				inner_cnt_q <= '0;
				axis_cnt_q  <= last_axis ? '0 : step + 1'b1;
			end else begin
				inner_cnt_q <= pos + 1'b1;
			end
		end
	end

	always_comb begin
		item.key        = {~value[AAM_VALUE_W-1], value[AAM_VALUE_W-2:0]};
		item.pos        = pos;
		item.step       = step;
		item.first      = (axis_cnt_q == '0);
		item.last_axis  = last_axis;
		item.last_inner = last_inner;
	end

	assign find_minimum = find_minimum_q;

endmodule

FILE: hw/rtl/aam_update.sv
module aam_update
	import aam_pkg::*;
#(
	parameter int MAX_INNER = AAM_MAX_INNER
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  aam_item_t   item,
	input  logic        advance,
	input  logic        find_minimum,
	output aam_stage_t  stage,
	output aam_result_t result
);

	localparam int DEPTH = (MAX_INNER < AAM_POS_LIMIT) ? MAX_INNER : AAM_POS_LIMIT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [AAM_VALUE_W-1:0] value_mem [DEPTH];
	logic [AAM_INDEX_W-1:0] index_mem [DEPTH];

	logic                   valid_s1;
	aam_item_t              item_s1;
	logic [AAM_VALUE_W-1:0] rd_val_s1;
	logic [AAM_INDEX_W-1:0] rd_idx_s1;

	logic                   wb_valid_q;
	logic [AW-1:0]          wb_addr_q;
	logic [AAM_VALUE_W-1:0] wb_val_q;
	logic [AAM_INDEX_W-1:0] wb_idx_q;

	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          addr_s1;
	logic                   fwd;
	logic [AAM_VALUE_W-1:0] best_val;
	logic [AAM_INDEX_W-1:0] best_idx;
	logic                   take;
	logic                   wr_en;
	logic [AAM_VALUE_W-1:0] wr_val;
	logic [AAM_INDEX_W-1:0] wr_idx;

	assign rd_addr = item.pos[AW-1:0];
	assign addr_s1 = item_s1.pos[AW-1:0];
	assign wr_en   = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wb_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				wb_valid_q <= 1'b1;
			end
		end
	end

	// The read at load time can miss a write made on the same edge; the last
	// write is kept aside and always equals what the table holds at its address.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1   <= item;
			rd_val_s1 <= value_mem[rd_addr];
			rd_idx_s1 <= index_mem[rd_addr];
		end
		if (wr_en) begin
			value_mem[addr_s1] <= wr_val;
			index_mem[addr_s1] <= wr_idx;
			wb_addr_q          <= addr_s1;
			wb_val_q           <= wr_val;
			wb_idx_q           <= wr_idx;
		end
	end

	assign fwd      = wb_valid_q && (wb_addr_q == addr_s1);
	assign best_val = fwd ? wb_val_q : rd_val_s1;
	assign best_idx = fwd ? wb_idx_q : rd_idx_s1;

	// Max mode replaces on ties, so the larger index wins; min mode keeps the earlier one.
	assign take = find_minimum ? (item_s1.key < best_val) : (item_s1.key >= best_val);

	always_comb begin
		if (item_s1.first) begin
			wr_val = item_s1.key;
			wr_idx = '0;
		end else if (take) begin
			wr_val = item_s1.key;
			wr_idx = item_s1.step;
		end else begin
			wr_val = best_val;
			wr_idx = best_idx;
		end
	end

	always_comb begin
		stage.valid       = valid_s1;
		stage.last_axis   = item_s1.last_axis;
		result.best_index = wr_idx;
		result.pos        = item_s1.pos;
		result.last_inner = item_s1.last_inner;
	end

endmodule

FILE: hw/rtl/axis_argmax_argmin.sv
// Streaming argmax / argmin along one tensor axis. Elements arrive in memory order
// [outer][axis][inner] as signed 64-bit values, one transaction per clock cycle at
// full rate. For each inner position the block keeps the best value and its axis
// index in two on-chip tables, read when an element is accepted and written back
// when it leaves the update stage; a write to the same position on the next
// element is forwarded, so consecutive elements never wait on each other. On the
// last axis step of a position a result carrying the winning index, the inner
// position and a slice-end flag (set on the last position of an outer slice)
// passes from the update stage into the output register and is presented from
// there until it is taken. The input only stalls while a finished result waits
// in the output register. In max mode ties go to the larger index, in min mode
// to the smaller one. An axis_length or inner_length of zero acts as one and
// values beyond the supported range saturate. The tables need no clearing after
// reset, since the first axis step of each position overwrites its entry. Write
// configuration only while the block is idle.
module axis_argmax_argmin
	import aam_pkg::*;
#(
	parameter int MAX_INNER = AAM_MAX_INNER
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      cfg_we,
	input  logic [AAM_CFG_IDX_W-1:0]  cfg_index,
	input  logic [AAM_CFG_DATA_W-1:0] cfg_data,
	// Element input channel.
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [AAM_VALUE_W-1:0]    value,
	// Result output channel.
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [AAM_INDEX_W-1:0]    best_position,
	output logic [AAM_POS_W-1:0]      inner_position,
	output logic                      slice_end
);

	aam_item_t   item;
	aam_stage_t  stage;
	aam_result_t result;
	logic        find_minimum;
	logic        accept;
	logic        advance;

	logic                   out_valid_q;
	logic [AAM_INDEX_W-1:0] best_position_q;
	logic [AAM_POS_W-1:0]   inner_position_q;
	logic                   slice_end_q;

	// The update stage drains whenever its element makes no result or the output
	// register is free or being emptied in this cycle; a new element enters
	// whenever the stage is empty or draining.
	assign advance  = stage.valid && (!stage.last_axis || !out_valid_q || out_ready);
	assign in_ready = !stage.valid || advance;
	assign accept   = in_valid && in_ready;

	aam_sequencer #(
		.MAX_INNER(MAX_INNER)
	) u_sequencer (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.value        (value),
		.item         (item),
		.find_minimum (find_minimum)
	);

	aam_update #(
		.MAX_INNER(MAX_INNER)
	) u_update (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.item         (item),
		.advance      (advance),
		.find_minimum (find_minimum),
		.stage        (stage),
		.result       (result)
	);

	// Output register: holds a finished result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && stage.last_axis) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stage.last_axis) begin
			best_position_q  <= result.best_index;
			inner_position_q <= result.pos;
			slice_end_q      <= result.last_inner;
		end
	end

	assign out_valid      = out_valid_q;
	assign best_position  = best_position_q;
	assign inner_position = inner_position_q;
	assign slice_end      = slice_end_q;

`ifndef NO_ASSERTIONS
	// Input stalls only when a result-bearing element is blocked by a full output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (stage.valid && stage.last_axis && out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// An element that completes its axis always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stage.last_axis) |=> out_valid)
		else $error("finished result was not presented");

	// The update stage never loses an element: it stays occupied unless it drains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stage.valid && !advance) |=> stage.valid)
		else $error("update stage dropped an element");
`endif

endmodule

FILE: test/tb_axis_argmax_argmin.sv
`timescale 1ns / 100ps

// Testbench for the streaming argmax / argmin block.
//
// Elements are sent one transaction at a time on the input channel. As each
// one is accepted, a predictor in this module updates its own copy of the
// per-position best values, best indexes and axis / inner counters. When the
// element is the last axis step for its position, the predictor queues the
// winning index. A receive process compares every result transaction with the
// oldest queued winner, field by field. Both sides insert random idle cycles,
// and the run ends with a drain, a short settle and a single verdict line.
module tb_axis_argmax_argmin;
	import aam_pkg::*;

	// The inner table saturates at the smaller of its depth and the position field's reach.
	localparam int INNER_HI = (AAM_MAX_INNER < AAM_POS_LIMIT) ? AAM_MAX_INNER : AAM_POS_LIMIT;
	// Margin after the drain for elements that produce no result but may still be
	// inside the block.
	localparam int SETTLE_CYCLES = 8;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 540;
	// Positions visited while the inner length sits at its saturated value.
	localparam int INNER_SWEEP = 48;

	localparam logic [AAM_VALUE_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [AAM_VALUE_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [AAM_VALUE_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	// Value patterns for the random phases.
	localparam int FLAVOR_WIDE    = 0;	// full 64-bit random
	localparam int FLAVOR_TIES    = 1;	// a handful of small values, so ties are common
	localparam int FLAVOR_EXTREME = 2;	// mostly the corners of the signed range and values near zero

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [AAM_CFG_IDX_W-1:0]  cfg_index = CFG_FIND_MINIMUM;
	logic [AAM_CFG_DATA_W-1:0] cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [AAM_VALUE_W-1:0]    value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [AAM_INDEX_W-1:0]    best_position;
	logic [AAM_POS_W-1:0]      inner_position;
	logic                      slice_end;

	axis_argmax_argmin dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.best_position (best_position),
		.inner_position(inner_position),
		.slice_end     (slice_end)
	);

	always #1 clk = ~clk;

	// Predictor state. The registers and the counters start at their reset values.
	logic [AAM_VALUE_W-1:0]    best_key [INNER_HI];
	logic [AAM_INDEX_W-1:0]    best_idx [INNER_HI];
	int unsigned               axis_step = 0;
	int unsigned               inner_slot = 0;
	logic                      mode_min = 1'b0;
	logic [AAM_CFG_DATA_W-1:0] axis_reg = 1;
	logic [AAM_CFG_DATA_W-1:0] inner_reg = 1;

	// Winners predicted but not yet seen on the output channel, oldest first.
	aam_result_t winners_due[$];
	aam_result_t want_result;

	int          errors = 0;
	bit          gaps_on = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned rx_stall = 0;

	// A length of zero behaves as one, and a length past the supported range saturates.
	function automatic int unsigned clamp_length(input int unsigned len, input int unsigned hi);
		if (len == 0) begin
			return 1;
		end
		return (len > hi) ? hi : len;
	endfunction

	// Advances the predictor by one accepted element and queues the winner when
	// the element closes its position's axis run.
	task automatic track_element(input logic [AAM_VALUE_W-1:0] v);
		int unsigned na;
		int unsigned ni;
		int unsigned slot;
		int unsigned axis_idx;
		logic [AAM_VALUE_W-1:0] key;
		logic take;
		logic at_axis_end;
		logic at_inner_end;
		aam_result_t res;
		na = clamp_length(axis_reg, AAM_AXIS_HI_INT);
		ni = clamp_length(inner_reg, INNER_HI);
		// After a mid-stream change of length, a counter at or past the new last
		// position is treated as sitting on the last position.
		slot = (inner_slot >= ni) ? ni - 1 : inner_slot;
		axis_idx = (axis_step >= na) ? na - 1 : axis_step;
		at_axis_end = (axis_idx == na - 1);
		at_inner_end = (slot == ni - 1);
		// Flipping the sign bit turns a signed order into an unsigned one.
		key = v ^ INT64_MIN;
		if (axis_step == 0) begin
			best_key[slot] = key;
			best_idx[slot] = '0;
		end else begin
			// Argmax lets a tie move to the later index, argmin keeps the earlier one.
			take = mode_min ? (key < best_key[slot]) : (key >= best_key[slot]);
			if (take) begin
				best_key[slot] = key;
				best_idx[slot] = AAM_INDEX_W'(axis_idx);
			end
		end
		if (at_axis_end) begin
			res.best_index = best_idx[slot];
			res.pos = AAM_POS_W'(slot);
			res.last_inner = at_inner_end;
			winners_due.push_back(res);
		end
		if (at_inner_end) begin
			inner_slot = 0;
			axis_step = at_axis_end ? 0 : ((axis_idx + 1) & 32'hFFFF);
		end else begin
			inner_slot = (slot + 1) & 32'h3FF;
		end
	endtask

	// Receive side: checks each result transaction against the oldest winner and
	// draws a fresh stall after each one.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (winners_due.size() == 0) begin
				errors++;
				$error("result with none pending: best_position %0d inner_position %0d slice_end %0b",
					best_position, inner_position, slice_end);
			end else begin
				want_result = winners_due.pop_front();
				if (best_position !== want_result.best_index) begin
					errors++;
					$error("best_position: expected %0d, actual %0d",
						want_result.best_index, best_position);
				end
				if (inner_position !== want_result.pos) begin
					errors++;
					$error("inner_position: expected %0d, actual %0d",
						want_result.pos, inner_position);
				end
				if (slice_end !== want_result.last_inner) begin
					errors++;
					$error("slice_end: expected %0b, actual %0b",
						want_result.last_inner, slice_end);
				end
			end
			rx_stall = gaps_on ? $urandom_range(0, 7) : 0;
		end
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Hang detection: any transaction, register write or reset cycle restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one element. Valid stays high after the transaction, so back-to-back
	// elements with no gap keep it high without a glitch. Callers that pause
	// lower it themselves.
	task automatic send_element(input logic [AAM_VALUE_W-1:0] v);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!in_ready);
		track_element(v);
	endtask

	// Stops sending and waits until every predicted winner has come out.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (winners_due.size() != 0);
	endtask

	// Drains, then lets elements that produce no result finish inside the block.
	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes raise the write enable, then lower it. The wait after lowering keeps
	// the enable from being lowered and raised in the same step when writes follow each other.
	task automatic write_reg(input logic [AAM_CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= AAM_CFG_DATA_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FIND_MINIMUM: mode_min = data[0];
			CFG_AXIS_LENGTH:  axis_reg = AAM_CFG_DATA_W'(data);
			CFG_INNER_LENGTH: inner_reg = AAM_CFG_DATA_W'(data & 32'h7FF);
			default: ;
		endcase
	endtask

	task automatic configure(input bit find_min, input int unsigned axis_len,
		input int unsigned inner_len);
		settle();
		write_reg(CFG_FIND_MINIMUM, find_min);
		write_reg(CFG_AXIS_LENGTH, axis_len);
		write_reg(CFG_INNER_LENGTH, inner_len);
	endtask

	function automatic logic [AAM_VALUE_W-1:0] draw_value(input int flavor);
		int d;
		case (flavor)
			FLAVOR_TIES: begin
				d = int'($urandom_range(0, 4)) - 2;
				return {{32{d[31]}}, d};
			end
			FLAVOR_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return INT64_MIN;
					1: return INT64_MAX;
					2: return '0;
					3: return ALL_ONES;
					4: return 64'd1;
					default: return {$urandom, $urandom};
				endcase
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Signed corners, ties in both modes, and interleaved positions.
	task automatic test_ties_and_extremes();
		configure(1'b0, 4, 1);
		// Two maxima tie, so argmax picks the later one.
		send_element(INT64_MIN);
		send_element(INT64_MAX);
		send_element(INT64_MAX);
		send_element(INT64_MIN);
		configure(1'b1, 4, 1);
		// Two minima tie, so argmin keeps the earlier one.
		send_element(INT64_MAX);
		send_element(INT64_MIN);
		send_element('0);
		send_element(INT64_MIN);
		configure(1'b0, 2, 2);
		send_element(ALL_ONES);
		send_element('0);
		send_element(64'd1);
		send_element(ALL_ONES);
	endtask

	// Zero lengths act as one: every element is its own slice.
	task automatic test_zero_lengths();
		configure(1'b1, 0, 0);
		send_element(INT64_MAX);
		send_element(INT64_MIN);
	endtask

	// Lengths shrink while a slice is open. The counters keep running, and one at
	// or past the new last position acts as the last position. Every position
	// read here was written by its first axis step in the same slice.
	task automatic test_midstream_changes();
		configure(1'b0, 4, 3);
		repeat (6) send_element(draw_value(FLAVOR_TIES));
		settle();
		write_reg(CFG_AXIS_LENGTH, 2);
		repeat (3) send_element(draw_value(FLAVOR_TIES));

		configure(1'b1, 2, 4);
		repeat (3) send_element(draw_value(FLAVOR_TIES));
		settle();
		write_reg(CFG_INNER_LENGTH, 2);
		repeat (3) send_element(draw_value(FLAVOR_TIES));

		// An oversized axis length saturates instead of wrapping, so the slice stays
		// open until the length is cut back.
		configure(1'b0, 32'h1FFFF, 2);
		repeat (6) send_element(draw_value(FLAVOR_WIDE));
		settle();
		write_reg(CFG_AXIS_LENGTH, 2);
		repeat (2) send_element(draw_value(FLAVOR_WIDE));
	endtask

	// An oversized inner length saturates at the table depth. With one axis step,
	// every element produces a result and the positions climb without closing the
	// slice; cutting the length back to one then closes it on the next element.
	task automatic test_inner_saturation();
		configure(1'b0, 1, 32'h7FF);
		repeat (INNER_SWEEP) send_element(draw_value(FLAVOR_WIDE));
		settle();
		write_reg(CFG_INNER_LENGTH, 1);
		send_element(draw_value(FLAVOR_WIDE));
	endtask

	// Whole slices with random lengths, modes, value patterns and idling. Now and
	// then the sender pauses until every pending result is out.
	task automatic test_random_phases();
		int unsigned sent;
		int unsigned al;
		int unsigned il;
		int unsigned count;
		int flavor;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: al = 0;
				1: al = $urandom_range(8, 24);
				default: al = $urandom_range(1, 5);
			endcase
			case ($urandom_range(0, 9))
				0: il = 0;
				1: il = $urandom_range(6, 12);
				default: il = $urandom_range(1, 4);
			endcase
			configure($urandom_range(0, 1), al, il);
			count = clamp_length(al, AAM_AXIS_HI_INT) * clamp_length(il, INNER_HI);
			if (count < 64) begin
				count = count * $urandom_range(1, 3);
			end
			flavor = $urandom_range(FLAVOR_WIDE, FLAVOR_EXTREME);
			repeat (count) begin
				if ($urandom_range(0, 63) == 0) begin
					hold_until_drained();
				end
				// Mostly the phase's own pattern, with a few others mixed in.
				if ($urandom_range(0, 7) == 0) begin
					send_element(draw_value($urandom_range(FLAVOR_WIDE, FLAVOR_EXTREME)));
				end else begin
					send_element(draw_value(flavor));
				end
			end
			sent += count;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;
		test_ties_and_extremes();
		test_zero_lengths();
		test_midstream_changes();
		test_inner_saturation();
		test_random_phases();
		settle();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/aam_pkg.sv
hw/rtl/aam_sequencer.sv
hw/rtl/aam_update.sv
hw/rtl/axis_argmax_argmin.sv
test/tb_axis_argmax_argmin.sv
